// ===== design/c2d_pkg.sv =====
package c2d_pkg;

  // payload field widths
  localparam int FUNC_W   = 2;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 5;
  localparam int CHAN_W   = 3;
  localparam int FILT_W   = 4;
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 32;

  // configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IN_CHANNELS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NUM_FILTERS   = 3'd5;

  // register widths and reset values
  localparam int IN_DIM_W  = 6;
  localparam int IN_CH_W   = 4;
  localparam int KER_W     = 3;
  localparam int NFILT_W   = 5;

  localparam logic [IN_DIM_W-1:0] IN_HEIGHT_RST     = 6'd32;
  localparam logic [IN_DIM_W-1:0] IN_WIDTH_RST      = 6'd32;
  localparam logic [IN_CH_W-1:0]  IN_CHANNELS_RST   = 4'd8;
  localparam logic [KER_W-1:0]    KERNEL_HEIGHT_RST = 3'd3;
  localparam logic [KER_W-1:0]    KERNEL_WIDTH_RST  = 3'd3;
  localparam logic [NFILT_W-1:0]  NUM_FILTERS_RST   = 5'd16;

  // transaction kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_WEIGHT  = 2'd1,
    FUNC_BIAS    = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_BIAS,
    ST_FINISH
  } state_t;

  // register value as used: zero reads as one, above the limit reads as the limit
  function automatic int clamp_reg(input int v, input int mx);
    int r;
    r = v;
    if (r == 0) r = 1;
    if (r > mx) r = mx;
    return r;
  endfunction

endpackage

// ===== design/c2d_in_if.sv =====
interface c2d_in_if;
  import c2d_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [CHAN_W-1:0]   chan;
  logic [FILT_W-1:0]   filt;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, func, row, col, chan, filt, value, input ready);
  modport sink   (input valid, func, row, col, chan, filt, value, output ready);
endinterface

interface c2d_out_if;
  import c2d_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result;
  logic                       err;

  modport source (output valid, result, err, input ready);
  modport sink   (input valid, result, err, output ready);
endinterface

// ===== design/c2d_ram.sv =====
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/conv2d_layer_mac_unit.sv =====
// compute transaction: N taps, N = channels * kh * kw
// (default 8 * 3 * 3 = 72), summed by one shared multiply-accumulate walking the taps
// one per cycle through the sample and weight memory read ports
// load transactions are taken in the idle state; a compute outside the output map skips the taps
// rst_n is synchronous, active low; registers return to 32, 32, 8, 3, 3, 16;
// the sample, weight and bias memories are not cleared and hold nothing until loaded
module conv2d_layer_mac_unit #(
  parameter int MAX_DIM      = 32,
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_KERNEL   = 5,
  parameter int MAX_FILTERS  = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  c2d_in_if.sink                            in_if,
  c2d_out_if.source                         out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c2d_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [c2d_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [c2d_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import c2d_pkg::*;

  localparam int STORE_BITS = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
  localparam int S_DEPTH    = MAX_DIM * MAX_DIM * MAX_CHANNELS;
  localparam int W_DEPTH    = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int B_DEPTH    = MAX_FILTERS;
  localparam int SA_W       = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
  localparam int WA_W       = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int BA_W       = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KI_W       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int TAPS       = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int PROD_W     = 2 * STORE_BITS;
  localparam int ACC_RAW_W  = PROD_W + $clog2(TAPS + 1) + 2;
  localparam int ACC_W      = (ACC_RAW_W > RESULT_W + 2) ? ACC_RAW_W : RESULT_W + 2;

  // configuration registers
  logic [IN_DIM_W-1:0] in_height_r, in_width_r;
  logic [IN_CH_W-1:0]  in_channels_r;
  logic [KER_W-1:0]    kernel_height_r, kernel_width_r;
  logic [NFILT_W-1:0]  num_filters_r;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[REG_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r     <= IN_HEIGHT_RST;
      in_width_r      <= IN_WIDTH_RST;
      in_channels_r   <= IN_CHANNELS_RST;
      kernel_height_r <= KERNEL_HEIGHT_RST;
      kernel_width_r  <= KERNEL_WIDTH_RST;
      num_filters_r   <= NUM_FILTERS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IN_HEIGHT:     in_height_r     <= pwdata[IN_DIM_W-1:0];
        REG_IN_WIDTH:      in_width_r      <= pwdata[IN_DIM_W-1:0];
        REG_IN_CHANNELS:   in_channels_r   <= pwdata[IN_CH_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height_r <= pwdata[KER_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width_r  <= pwdata[KER_W-1:0];
        REG_NUM_FILTERS:   num_filters_r   <= pwdata[NFILT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_IN_HEIGHT:     prdata = APB_DATA_W'(in_height_r);
      REG_IN_WIDTH:      prdata = APB_DATA_W'(in_width_r);
      REG_IN_CHANNELS:   prdata = APB_DATA_W'(in_channels_r);
      REG_KERNEL_HEIGHT: prdata = APB_DATA_W'(kernel_height_r);
      REG_KERNEL_WIDTH:  prdata = APB_DATA_W'(kernel_width_r);
      REG_NUM_FILTERS:   prdata = APB_DATA_W'(num_filters_r);
      default:           prdata = '0;
    endcase
  end

  // register values as used, and the output map bounds
  int ih_use, iw_use, nc_use, kh_use, kw_use, nf_use, oh, ow;

  always_comb begin
    ih_use = clamp_reg(int'(in_height_r), MAX_DIM);
    iw_use = clamp_reg(int'(in_width_r), MAX_DIM);
    nc_use = clamp_reg(int'(in_channels_r), MAX_CHANNELS);
    kh_use = clamp_reg(int'(kernel_height_r), MAX_KERNEL);
    kw_use = clamp_reg(int'(kernel_width_r), MAX_KERNEL);
    nf_use = clamp_reg(int'(num_filters_r), MAX_FILTERS);
    oh     = (ih_use >= kh_use) ? ih_use - kh_use + 1 : 0;
    ow     = (iw_use >= kw_use) ? iw_use - kw_use + 1 : 0;
  end

  logic [CH_W-1:0] ch_last;
  logic [KI_W-1:0] kr_last, kc_last;

  assign ch_last = CH_W'(nc_use - 1);
  assign kr_last = KI_W'(kh_use - 1);
  assign kc_last = KI_W'(kw_use - 1);

  // sequencer control
  state_t state_r, state_nxt;
  logic   in_ready, issue, bias_add, out_load;
  logic   in_fire, tap_last, err_req;
  func_t  in_func;

  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [FILT_W-1:0] filt_r;
  logic              err_r;
  logic [CH_W-1:0]   ch_r;
  logic [KI_W-1:0]   kr_r, kc_r;

  logic v1_r, last1_r, v2_r, last2_r, v3_r, last3_r;

  assign in_func  = func_t'(in_if.func);
  assign in_fire  = in_if.valid && in_ready;
  assign tap_last = (ch_r == ch_last) && (kr_r == kr_last) && (kc_r == kc_last);
  assign err_req  = (int'(in_if.row) >= oh) || (int'(in_if.col) >= ow) ||
                    (int'(in_if.filt) >= nf_use);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_func == FUNC_COMPUTE) begin
          state_nxt = err_req ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (v3_r && last3_r) state_nxt = ST_BIAS;
      end
      ST_BIAS: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    bias_add = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_RUN:    issue    = 1'b1;
      ST_DRAIN:  ;
      ST_BIAS:   bias_add = 1'b1;
      ST_FINISH: out_load = !out_if.valid || out_if.ready;
      default:   ;
    endcase
  end

  assign in_if.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // compute request capture and tap counters
  always_ff @(posedge clk) begin
    if (in_fire && in_func == FUNC_COMPUTE) begin
      row_r  <= in_if.row;
      col_r  <= in_if.col;
      filt_r <= in_if.filt;
      err_r  <= err_req;
      ch_r   <= '0;
      kr_r   <= '0;
      kc_r   <= '0;
    end else if (issue) begin
      if (kc_r == kc_last) begin
        kc_r <= '0;
        if (kr_r == kr_last) begin
          kr_r <= '0;
          ch_r <= ch_r + 1'b1;
        end else begin
          kr_r <= kr_r + 1'b1;
        end
      end else begin
        kc_r <= kc_r + 1'b1;
      end
    end
  end

  // load address decode
  logic            s_we, w_we, b_we;
  logic [SA_W-1:0] s_waddr;
  logic [WA_W-1:0] w_waddr;
  logic [BA_W-1:0] b_waddr;
  logic [STORE_BITS-1:0] wr_data;

  assign wr_data = in_if.value[STORE_BITS-1:0];
  assign s_waddr = SA_W'((int'(in_if.row) * MAX_DIM + int'(in_if.col)) * MAX_CHANNELS +
                         int'(in_if.chan));
  assign w_waddr = WA_W'(((int'(in_if.filt) * MAX_CHANNELS + int'(in_if.chan)) * MAX_KERNEL +
                          int'(in_if.row)) * MAX_KERNEL + int'(in_if.col));
  assign b_waddr = BA_W'(in_if.filt);

  always_comb begin
    s_we = 1'b0;
    w_we = 1'b0;
    b_we = 1'b0;
    if (in_fire) begin
      case (in_func)
        FUNC_SAMPLE: s_we = (int'(in_if.row) < MAX_DIM) && (int'(in_if.col) < MAX_DIM) &&
                            (int'(in_if.chan) < MAX_CHANNELS);
        FUNC_WEIGHT: w_we = (int'(in_if.row) < MAX_KERNEL) && (int'(in_if.col) < MAX_KERNEL) &&
                            (int'(in_if.chan) < MAX_CHANNELS) &&
                            (int'(in_if.filt) < MAX_FILTERS);
        FUNC_BIAS:   b_we = int'(in_if.filt) < MAX_FILTERS;
        default:     ;
      endcase
    end
  end

  // tap address stage
  logic [SA_W-1:0] s_raddr_r;
  logic [WA_W-1:0] w_raddr_r;

  always_ff @(posedge clk) begin
    s_raddr_r <= SA_W'(((int'(row_r) + int'(kr_r)) * MAX_DIM + int'(col_r) + int'(kc_r)) *
                       MAX_CHANNELS + int'(ch_r));
    w_raddr_r <= WA_W'(((int'(filt_r) * MAX_CHANNELS + int'(ch_r)) * MAX_KERNEL +
                        int'(kr_r)) * MAX_KERNEL + int'(kc_r));
  end

  // memories
  logic [STORE_BITS-1:0] s_rdata, w_rdata, b_rdata;

  c2d_ram #(.WIDTH(STORE_BITS), .DEPTH(S_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (wr_data),
    .raddr (s_raddr_r),
    .rdata (s_rdata)
  );

  c2d_ram #(.WIDTH(STORE_BITS), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (wr_data),
    .raddr (w_raddr_r),
    .rdata (w_rdata)
  );

  c2d_ram #(.WIDTH(STORE_BITS), .DEPTH(B_DEPTH)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wr_data),
    .raddr (BA_W'(filt_r)),
    .rdata (b_rdata)
  );

  // tap valid and last flags along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    last1_r <= tap_last;
    last2_r <= last1_r;
    last3_r <= last2_r;
  end

  // shared multiplier
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'($signed(s_rdata)) * PROD_W'($signed(w_rdata));
  end

  // accumulator, with the bias added in Q16.16 at the end
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (in_fire) begin
      acc_nxt = '0;
    end else if (v3_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else if (bias_add) begin
      acc_nxt = acc_r + (ACC_W'($signed(b_rdata)) <<< 8);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // saturate to 32 bits
  logic signed [RESULT_W-1:0] sat_val;
  logic [ACC_W-RESULT_W:0]    acc_top;

  assign acc_top = acc_r[ACC_W-1:RESULT_W-1];

  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      sat_val = acc_r[RESULT_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_val = {1'b1, {(RESULT_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  // output register
  logic                       out_valid_r;
  logic signed [RESULT_W-1:0] out_result_r;
  logic                       out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_r <= err_r ? '0 : sat_val;
      out_err_r    <= err_r;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.result = out_result_r;
  assign out_if.err    = out_err_r;

endmodule

// ===== verif/conv_result_check.sv =====
`timescale 1ns / 1ps

module conv_result_check (
  input  logic                           clk,
  input  logic                           rst_n,
  c2d_in_if                              in_mon,
  c2d_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [c2d_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [c2d_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             mismatch_count,
  output int                             results_due
);
  import c2d_pkg::*;

  localparam int DIM      = 32;
  localparam int CHANNELS = 8;
  localparam int KERNEL   = 5;
  localparam int FILTERS  = 16;

  typedef struct {
    logic [RESULT_W-1:0] result;
    logic                err;
  } conv_result_t;

  conv_result_t expected_q[$];

  // local copy of the three stores
  logic signed [VALUE_W-1:0] sample_mem [0:DIM-1][0:DIM-1][0:CHANNELS-1];
  logic signed [VALUE_W-1:0] weight_mem [0:FILTERS-1][0:CHANNELS-1][0:KERNEL-1][0:KERNEL-1];
  logic signed [VALUE_W-1:0] bias_mem   [0:FILTERS-1];

  // local copy of the registers as written
  logic [IN_DIM_W-1:0] height_cfg, width_cfg;
  logic [IN_CH_W-1:0]  chan_cfg;
  logic [KER_W-1:0]    kh_cfg, kw_cfg;
  logic [NFILT_W-1:0]  filt_cfg;

  // zero counts as one, anything past the limit as the limit
  function automatic int in_use(input int raw, input int lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // one output value: window sum plus shifted bias, saturated to 32 bits
  function automatic conv_result_t conv_output(input int orow, input int ocol,
                                               input int ofilt);
    conv_result_t res;
    int ih, iw, nc, kh, kw, nf, oh, ow;
    longint acc;
    ih = in_use(int'(height_cfg), DIM);
    iw = in_use(int'(width_cfg), DIM);
    nc = in_use(int'(chan_cfg), CHANNELS);
    kh = in_use(int'(kh_cfg), KERNEL);
    kw = in_use(int'(kw_cfg), KERNEL);
    nf = in_use(int'(filt_cfg), FILTERS);
    oh = (ih >= kh) ? ih - kh + 1 : 0;
    ow = (iw >= kw) ? iw - kw + 1 : 0;
    res.result = '0;
    res.err    = 1'b1;
    if (orow >= oh || ocol >= ow || ofilt >= nf) return res;
    acc = 0;
    for (int c = 0; c < nc; c++)
      for (int r = 0; r < kh; r++)
        for (int s = 0; s < kw; s++)
          acc += longint'(sample_mem[orow+r][ocol+s][c]) *
                 longint'(weight_mem[ofilt][c][r][s]);
    acc += longint'(bias_mem[ofilt]) * 256;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    res.result = acc[RESULT_W-1:0];
    res.err    = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : observe
    conv_result_t want;
    if (!rst_n) begin
      height_cfg = IN_HEIGHT_RST;
      width_cfg  = IN_WIDTH_RST;
      chan_cfg   = IN_CHANNELS_RST;
      kh_cfg     = KERNEL_HEIGHT_RST;
      kw_cfg     = KERNEL_WIDTH_RST;
      filt_cfg   = NUM_FILTERS_RST;
      expected_q.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_IN_HEIGHT:     height_cfg = pwdata[IN_DIM_W-1:0];
          REG_IN_WIDTH:      width_cfg  = pwdata[IN_DIM_W-1:0];
          REG_IN_CHANNELS:   chan_cfg   = pwdata[IN_CH_W-1:0];
          REG_KERNEL_HEIGHT: kh_cfg     = pwdata[KER_W-1:0];
          REG_KERNEL_WIDTH:  kw_cfg     = pwdata[KER_W-1:0];
          REG_NUM_FILTERS:   filt_cfg   = pwdata[NFILT_W-1:0];
          default: ;
        endcase
      end

      // input transaction: loads update the stores, a compute queues its result
      if (in_mon.valid && in_mon.ready) begin
        case (func_t'(in_mon.func))
          FUNC_SAMPLE: sample_mem[in_mon.row][in_mon.col][in_mon.chan] = in_mon.value;
          FUNC_WEIGHT: begin
            if (in_mon.row < KERNEL && in_mon.col < KERNEL)
              weight_mem[in_mon.filt][in_mon.chan][in_mon.row][in_mon.col] = in_mon.value;
          end
          FUNC_BIAS: bias_mem[in_mon.filt] = in_mon.value;
          default: expected_q.push_back(conv_output(int'(in_mon.row), int'(in_mon.col),
                                                    int'(in_mon.filt)));
        endcase
      end

      // result transaction against the oldest queued value
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] result %0d err %0b with nothing queued", $time,
                     $signed(out_mon.result), out_mon.err);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.result !== want.result || out_mon.err !== want.err) begin
            if (mismatch_count < 10)
              $display("[%0t] mismatch: result exp %0d got %0d, err exp %0b got %0b",
                       $time, $signed(want.result), $signed(out_mon.result),
                       want.err, out_mon.err);
            mismatch_count++;
          end
        end
      end
    end
    results_due = expected_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import c2d_pkg::*;

  localparam int ITEM_TARGET   = 1100;
  localparam int MIN_COMPUTES  = 60;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 256;

  logic                  clk;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    results_due;

  c2d_in_if  in_bus();
  c2d_out_if out_bus();

  conv2d_layer_mac_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  conv_result_check result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // register values in use and the resulting output map
  int eff_ih = int'(IN_HEIGHT_RST);
  int eff_iw = int'(IN_WIDTH_RST);
  int eff_nc = int'(IN_CHANNELS_RST);
  int eff_kh = int'(KERNEL_HEIGHT_RST);
  int eff_kw = int'(KERNEL_WIDTH_RST);
  int eff_nf = int'(NUM_FILTERS_RST);
  int out_h  = 30;
  int out_w  = 30;

  // store entries written so far, so that no compute reads an empty one
  bit sample_ok [0:31][0:31][0:7];
  bit weight_ok [0:15][0:7][0:4][0:4];
  bit bias_ok   [0:15];

  int items_sent    = 0;
  int computes_sent = 0;
  int reach         = 31;
  bit calm          = 1'b0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure in bursts
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  function automatic int in_use(input int raw, input int lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // extremes, small magnitudes and full random words
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3, 4:    return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drop_valid();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic send_item(input func_t kind, input int r, input int c, input int ch,
                           input int f, input logic [VALUE_W-1:0] v);
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.func  <= kind;
    in_bus.row   <= r[ROW_W-1:0];
    in_bus.col   <= c[COL_W-1:0];
    in_bus.chan  <= ch[CHAN_W-1:0];
    in_bus.filt  <= f[FILT_W-1:0];
    in_bus.value <= v;
    do @(posedge clk); while (!in_bus.ready);
    // bookkeeping of written entries; weight loads past the kernel are dropped
    case (kind)
      FUNC_SAMPLE: sample_ok[r][c][ch] = 1'b1;
      FUNC_WEIGHT: if (r < 5 && c < 5) weight_ok[f][ch][r][c] = 1'b1;
      FUNC_BIAS:   bias_ok[f] = 1'b1;
      default:     computes_sent++;
    endcase
    items_sent++;
    // sender gap
    if (!calm && $urandom_range(0, 5) == 0) begin
      drop_valid();
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // registers change only once the block has gone quiet
  task automatic write_config(input int ih, input int iw, input int nc, input int kh,
                              input int kw, input int nf);
    drop_valid();
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_write(REG_IN_HEIGHT, ih);
    apb_write(REG_IN_WIDTH, iw);
    apb_write(REG_IN_CHANNELS, nc);
    apb_write(REG_KERNEL_HEIGHT, kh);
    apb_write(REG_KERNEL_WIDTH, kw);
    apb_write(REG_NUM_FILTERS, nf);
    eff_ih = in_use(ih, 32);
    eff_iw = in_use(iw, 32);
    eff_nc = in_use(nc, 8);
    eff_kh = in_use(kh, 5);
    eff_kw = in_use(kw, 5);
    eff_nf = in_use(nf, 16);
    out_h  = (eff_ih >= eff_kh) ? eff_ih - eff_kh + 1 : 0;
    out_w  = (eff_iw >= eff_kw) ? eff_iw - eff_kw + 1 : 0;
  endtask

  // fill any empty entry of the window, and now and then refresh a full one
  task automatic ensure_window(input int r, input int c, input int f);
    for (int ch = 0; ch < eff_nc; ch++)
      for (int kr = 0; kr < eff_kh; kr++)
        for (int kc = 0; kc < eff_kw; kc++) begin
          if (!sample_ok[r+kr][c+kc][ch] || $urandom_range(0, 15) == 0)
            send_item(FUNC_SAMPLE, r + kr, c + kc, ch, $urandom_range(0, 15), rand_value());
          if (!weight_ok[f][ch][kr][kc] || $urandom_range(0, 15) == 0)
            send_item(FUNC_WEIGHT, kr, kc, ch, f, rand_value());
        end
    if (!bias_ok[f] || $urandom_range(0, 7) == 0)
      send_item(FUNC_BIAS, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 7), f, rand_value());
  endtask

  task automatic well_formed_compute();
    int r, c, f;
    r = $urandom_range(0, (out_h - 1 < reach) ? out_h - 1 : reach);
    c = $urandom_range(0, (out_w - 1 < reach) ? out_w - 1 : reach);
    f = $urandom_range(0, (eff_nf - 1 < reach) ? eff_nf - 1 : reach);
    ensure_window(r, c, f);
    send_item(FUNC_COMPUTE, r, c, $urandom_range(0, 7), f, rand_value());
  endtask

  task automatic random_load();
    case ($urandom_range(0, 2))
      0: send_item(FUNC_SAMPLE, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 7), $urandom_range(0, 15), rand_value());
      1: send_item(FUNC_WEIGHT, $urandom_range(0, 4), $urandom_range(0, 4),
                   $urandom_range(0, 7), $urandom_range(0, 15), rand_value());
      default: send_item(FUNC_BIAS, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 7), $urandom_range(0, 15), rand_value());
    endcase
  endtask

  // weight load with a kernel row or column the store does not have
  task automatic dropped_load();
    if ($urandom_range(0, 1))
      send_item(FUNC_WEIGHT, $urandom_range(5, 31), $urandom_range(0, 31),
                $urandom_range(0, 7), $urandom_range(0, 15), rand_value());
    else
      send_item(FUNC_WEIGHT, $urandom_range(0, 31), $urandom_range(5, 31),
                $urandom_range(0, 7), $urandom_range(0, 15), rand_value());
  endtask

  // compute with at least one coordinate off the output map, or a random load if none can be
  task automatic stray_compute();
    bit can_r, can_c, can_f;
    int pick, r, c, f;
    can_r = out_h < 32;
    can_c = out_w < 32;
    can_f = eff_nf < 16;
    if (!(can_r || can_c || can_f)) begin
      random_load();
    end else begin
      do pick = $urandom_range(0, 2);
      while (!((pick == 0 && can_r) || (pick == 1 && can_c) || (pick == 2 && can_f)));
      r = $urandom_range(0, 31);
      c = $urandom_range(0, 31);
      f = $urandom_range(0, 15);
      case (pick)
        0:       r = $urandom_range(out_h, 31);
        1:       c = $urandom_range(out_w, 31);
        default: f = $urandom_range(eff_nf, 15);
      endcase
      send_item(FUNC_COMPUTE, r, c, $urandom_range(0, 7), f, rand_value());
    end
  endtask

  task automatic run_phase(input int span);
    int start_items;
    start_items = items_sent;
    while (items_sent - start_items < span) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5, 6: begin
          if (out_h > 0 && out_w > 0) well_formed_compute();
          else stray_compute();
        end
        7, 8:    stray_compute();
        9:       random_load();
        10:      dropped_load();
        default: begin
          // hold the sender until every queued result is out
          drop_valid();
          while (results_due != 0) @(negedge clk);
        end
      endcase
    end
  endtask

  task automatic pick_config();
    case ($urandom_range(0, 5))
      0: begin
        // zero and oversize raw values on height, channels, kernel height, filters; kernel width zero to two
        reach = 1;
        write_config($urandom_range(0, 1) ? 0 : $urandom_range(33, 63),
                     $urandom_range(1, 8),
                     $urandom_range(0, 1) ? 0 : $urandom_range(9, 15),
                     $urandom_range(0, 1) ? 0 : $urandom_range(6, 7),
                     $urandom_range(0, 2),
                     $urandom_range(0, 1) ? 0 : $urandom_range(17, 31));
      end
      1: begin
        // zero and oversize raw values on width and kernel width
        reach = 3;
        write_config($urandom_range(1, 8),
                     $urandom_range(0, 1) ? 0 : $urandom_range(33, 63),
                     $urandom_range(1, 3), $urandom_range(1, 3),
                     $urandom_range(0, 1) ? 0 : $urandom_range(6, 7),
                     $urandom_range(1, 16));
      end
      default: begin
        reach = 31;
        write_config($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 3),
                     $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 16));
      end
    endcase
  endtask

  task automatic directed_checks();
    // reset registers give a 30 x 30 map, so row 31 is off the map
    send_item(FUNC_COMPUTE, 31, 0, 0, 0, 16'h0000);
    write_config(3, 3, 1, 2, 2, 2);
    // most negative samples and weights: the sum saturates high
    for (int k = 0; k < 4; k++) begin
      send_item(FUNC_SAMPLE, k / 2, k % 2, 0, 0, 16'h8000);
      send_item(FUNC_WEIGHT, k / 2, k % 2, 0, 0, 16'h8000);
    end
    send_item(FUNC_BIAS, 0, 0, 0, 0, 16'h7fff);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0000);
    // most positive weights on most negative samples: saturates low
    for (int k = 0; k < 4; k++)
      send_item(FUNC_WEIGHT, k / 2, k % 2, 0, 1, 16'h7fff);
    send_item(FUNC_BIAS, 0, 0, 0, 1, 16'h8000);
    send_item(FUNC_COMPUTE, 0, 0, 0, 1, 16'h0000);
    // kernel row past the store is dropped
    send_item(FUNC_WEIGHT, 5, 7, 7, 15, 16'hffff);
    // small exact sum with a negative bias
    for (int k = 0; k < 4; k++)
      send_item(FUNC_WEIGHT, k / 2, k % 2, 0, 0, (k == 0) ? 16'h0001 : 16'h0000);
    send_item(FUNC_BIAS, 0, 0, 0, 0, 16'hffff);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0000);
    // row, column and filter each off the map
    send_item(FUNC_COMPUTE, 2, 0, 0, 0, 16'h0000);
    send_item(FUNC_COMPUTE, 0, 31, 7, 0, 16'hffff);
    send_item(FUNC_COMPUTE, 0, 0, 0, 15, 16'h0000);
    // zero height read as one and kernel height 7 read as 5: empty map
    write_config(0, 3, 1, 7, 2, 2);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0000);
  endtask

  // main sequence
  initial begin
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_bus.valid = 1'b0;
    in_bus.func  = FUNC_SAMPLE;
    in_bus.row   = '0;
    in_bus.col   = '0;
    in_bus.chan  = '0;
    in_bus.filt  = '0;
    in_bus.value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_checks();

    // widest setting on one window
    write_config(32, 32, 8, 5, 5, 16);
    reach = 0;
    run_phase(430);

    while (items_sent < ITEM_TARGET || computes_sent < MIN_COMPUTES) begin
      if (items_sent > ITEM_TARGET * 4 / 5) calm = 1'b1;
      pick_config();
      run_phase($urandom_range(30, 90));
    end

    drop_valid();
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/c2d_pkg.sv
design/c2d_in_if.sv
design/c2d_ram.sv
design/conv2d_layer_mac_unit.sv
verif/conv_result_check.sv
verif/tb_top.sv
